// ===== hdl/emas_pkg.sv =====
// Shared constants and types for the encoder moving-average speed block.
`timescale 1ns / 1ps
package emas_pkg;

   localparam int WINDOW   = 8;
   localparam int RING_AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SAMPLE_W = 16;
   localparam int TOTAL_W  = 19;
   localparam int SPEED_W  = 21;
   localparam int GAIN_W   = 24;
   localparam int PROD_W   = TOTAL_W + GAIN_W;
   localparam int FRAC_W   = 16;
   localparam int QUOT_W   = PROD_W - FRAC_W;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic [RING_AW-1:0]  RING_LAST      = RING_AW'(WINDOW - 1);
   localparam logic [SAMPLE_W-1:0] COUNT_MIDPOINT = 16'h8000;
   localparam logic [GAIN_W-1:0]   GAIN_RESET     = 24'd49152;
   localparam logic [QUOT_W-1:0]   RPM_MAX        = QUOT_W'(1048575);
   localparam logic [QUOT_W-1:0]   RPM_MIN_MAG    = QUOT_W'(1048576);
   localparam logic [SPEED_W-1:0]  SPEED_POS_SAT  = 21'h0FFFFF;
   localparam logic [SPEED_W-1:0]  SPEED_NEG_MAG  = 21'h100000;

   localparam logic [CSR_AW-1:0]   CSR_RPM_GAIN   = 2'd0;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] delta;
      logic signed [TOTAL_W-1:0]  total;
   } ring_result_type;

endpackage

// ===== hdl/emas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module emas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/emas_ring.sv =====
// Delta formation and ring read-modify-write with the running window total.
`timescale 1ns / 1ps
module emas_ring (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [emas_pkg::SAMPLE_W-1:0]       req_count_sample,
   output logic                                down_valid,
   input  logic                                down_stall,
   output emas_pkg::ring_result_type           down_result
);

   logic [emas_pkg::RING_AW-1:0]  pos_ff, pos_in;
   logic [emas_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic                          s1_v_ff, s1_v_in;
   logic [emas_pkg::SAMPLE_W-1:0] s1_delta_ff, s1_delta_in;
   logic [emas_pkg::RING_AW-1:0]  s1_pos_ff;
   logic                          byp_v_ff, byp_v_in;
   logic [emas_pkg::SAMPLE_W-1:0] byp_data_ff;
   logic [emas_pkg::WINDOW-1:0]   entry_valid_ff;
   logic [emas_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [emas_pkg::SAMPLE_W-1:0] rd_data, old_delta;
   logic                          accept, advance;

   assign req_stall = s1_v_ff && down_stall;
   assign accept    = req_valid && !req_stall;
   assign advance   = s1_v_ff && !down_stall;

   assign s1_delta_in = req_count_sample - prev_ff;
   assign prev_in     = accept ? req_count_sample : prev_ff;
   assign pos_in      = !accept ? pos_ff :
                        (pos_ff == emas_pkg::RING_LAST) ? '0 :
                        pos_ff + emas_pkg::RING_AW'(1);
   assign s1_v_in     = accept ? 1'b1 : (advance ? 1'b0 : s1_v_ff);
   assign byp_v_in    = advance && (s1_pos_ff == pos_ff);

   emas_ram #(
      .WIDTH(emas_pkg::SAMPLE_W),
      .DEPTH(emas_pkg::WINDOW)
   ) u_ring_ram (
      .clock  (clock),
      .wr_en  (advance),
      .wr_addr(s1_pos_ff),
      .wr_data(s1_delta_ff),
      .rd_en  (accept),
      .rd_addr(pos_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      if (byp_v_ff) begin
         old_delta = byp_data_ff;
      end else if (entry_valid_ff[s1_pos_ff]) begin
         old_delta = rd_data;
      end else begin
         old_delta = '0;
      end
   end

   assign total_in = total_ff
                   - {{(emas_pkg::TOTAL_W - emas_pkg::SAMPLE_W){old_delta[15]}}, old_delta}
                   + {{(emas_pkg::TOTAL_W - emas_pkg::SAMPLE_W){s1_delta_ff[15]}},
                      s1_delta_ff};

   assign down_valid        = s1_v_ff;
   assign down_result.delta = s1_delta_ff;
   assign down_result.total = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         prev_ff        <= emas_pkg::COUNT_MIDPOINT;
         s1_v_ff        <= 1'b0;
         byp_v_ff       <= 1'b0;
         entry_valid_ff <= '0;
         total_ff       <= '0;
      end else begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         s1_v_ff <= s1_v_in;
         if (accept) begin
            byp_v_ff <= byp_v_in;
         end
         if (advance) begin
            entry_valid_ff[s1_pos_ff] <= 1'b1;
            total_ff                  <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_delta_ff <= s1_delta_in;
         s1_pos_ff   <= pos_ff;
         byp_data_ff <= s1_delta_ff;
      end
   end

endmodule

// ===== hdl/emas_speed.sv =====
// Gain multiply, truncation toward zero, saturation and the result register.
`timescale 1ns / 1ps
module emas_speed (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 up_valid,
   output logic                                 up_stall,
   input  emas_pkg::ring_result_type            up_result,
   input  logic [emas_pkg::GAIN_W-1:0]          rpm_gain,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [emas_pkg::SAMPLE_W-1:0] rsp_tick_delta,
   output logic signed [emas_pkg::TOTAL_W-1:0]  rsp_window_total,
   output logic signed [emas_pkg::SPEED_W-1:0]  rsp_speed_rpm
);

   logic                          a_v_ff, a_v_in;
   logic [emas_pkg::SAMPLE_W-1:0] a_delta_ff;
   logic [emas_pkg::TOTAL_W-1:0]  a_total_ff;
   logic                          a_neg_ff;
   logic [emas_pkg::TOTAL_W-1:0]  a_mag_ff;
   logic                          o_v_ff, o_v_in;
   logic [emas_pkg::SAMPLE_W-1:0] o_delta_ff;
   logic [emas_pkg::TOTAL_W-1:0]  o_total_ff;
   logic [emas_pkg::SPEED_W-1:0]  o_speed_ff, o_speed_in;
   logic [emas_pkg::TOTAL_W-1:0]  mag;
   logic [emas_pkg::PROD_W-1:0]   prod;
   logic [emas_pkg::QUOT_W-1:0]   quot;
   logic                          neg, o_load, a_load;

   assign o_load   = a_v_ff && (!o_v_ff || !rsp_stall);
   assign up_stall = a_v_ff && !o_load;
   assign a_load   = up_valid && !up_stall;
   assign a_v_in   = a_load ? 1'b1 : (o_load ? 1'b0 : a_v_ff);
   assign o_v_in   = o_load ? 1'b1 : ((o_v_ff && !rsp_stall) ? 1'b0 : o_v_ff);

   assign neg  = up_result.total[emas_pkg::TOTAL_W-1];
   assign mag  = neg ? ('0 - up_result.total) : up_result.total;
   assign prod = emas_pkg::PROD_W'(a_mag_ff) * emas_pkg::PROD_W'(rpm_gain);
   assign quot = prod[emas_pkg::PROD_W-1:emas_pkg::FRAC_W];

   always_comb begin
      if (a_neg_ff) begin
         o_speed_in = (quot > emas_pkg::RPM_MIN_MAG) ?
                      ('0 - emas_pkg::SPEED_NEG_MAG) :
                      ('0 - quot[emas_pkg::SPEED_W-1:0]);
      end else begin
         o_speed_in = (quot > emas_pkg::RPM_MAX) ?
                      emas_pkg::SPEED_POS_SAT : quot[emas_pkg::SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         o_v_ff <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_delta_ff <= up_result.delta;
         a_total_ff <= up_result.total;
         a_neg_ff   <= neg;
         a_mag_ff   <= mag;
      end
      if (o_load) begin
         o_delta_ff <= a_delta_ff;
         o_total_ff <= a_total_ff;
         o_speed_ff <= o_speed_in;
      end
   end

   assign rsp_valid        = o_v_ff;
   assign rsp_tick_delta   = o_delta_ff;
   assign rsp_window_total = o_total_ff;
   assign rsp_speed_rpm    = o_speed_ff;

endmodule

// ===== hdl/encoder_moving_average_speed.sv =====
// Top level of the encoder moving-average speed block with its register port.
//
// Each transfer on the req_ channel carries one 16-bit encoder counter sample.
// For every sample the block returns one transfer on the rsp_ channel with the
// wrapped signed delta from the previous sample, the sum of the last eight
// deltas and the speed in rpm, which is the sum times the Q16 gain rpm_gain,
// truncated toward zero and saturated to 21 bits.
// The delta ring sits in a small RAM; the slot leaving the window is read in
// the cycle the sample is taken and rewritten as the sample leaves the ring
// stage, with a bypass when the same slot is read and written back to back.
// A sample passes the ring stage, the multiply stage and the result register
// before rsp_valid rises. One sample per cycle is taken while rsp_stall is low.
// When rsp_stall is high, the result holds and the pipeline keeps filling;
// req_stall rises only once every stage holds a result.
// Reset clears the ring, the window sum and the pipeline, sets the previous
// count to 32768 and rpm_gain to 49152 (0.75). rpm_gain sits at address 0 of
// the csr_ port and should be written only while no samples are in flight.
`timescale 1ns / 1ps
module encoder_moving_average_speed (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [emas_pkg::SAMPLE_W-1:0]        req_count_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [emas_pkg::SAMPLE_W-1:0] rsp_tick_delta,
   output logic signed [emas_pkg::TOTAL_W-1:0]  rsp_window_total,
   output logic signed [emas_pkg::SPEED_W-1:0]  rsp_speed_rpm,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [emas_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [emas_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [emas_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                 csr_pready
);

   logic [emas_pkg::GAIN_W-1:0] gain_ff;
   logic                        gain_wr;
   logic                        mid_valid, mid_stall;
   emas_pkg::ring_result_type   mid_result;

   assign csr_pready = 1'b1;
   assign gain_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == emas_pkg::CSR_RPM_GAIN);
   assign csr_prdata = (csr_paddr == emas_pkg::CSR_RPM_GAIN) ?
                       emas_pkg::CSR_DW'(gain_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= emas_pkg::GAIN_RESET;
      end else if (gain_wr) begin
         gain_ff <= csr_pwdata[emas_pkg::GAIN_W-1:0];
      end
   end

   emas_ring u_ring (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_count_sample(req_count_sample),
      .down_valid      (mid_valid),
      .down_stall      (mid_stall),
      .down_result     (mid_result)
   );

   emas_speed u_speed (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (mid_valid),
      .up_stall        (mid_stall),
      .up_result       (mid_result),
      .rpm_gain        (gain_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tick_delta  (rsp_tick_delta),
      .rsp_window_total(rsp_window_total),
      .rsp_speed_rpm   (rsp_speed_rpm)
   );

endmodule

// ===== hdl/emas_checker.sv =====
// Port-level checks for the encoder moving-average speed block and their binding.
`timescale 1ns / 1ps
module emas_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [emas_pkg::SAMPLE_W-1:0] rsp_tick_delta,
   input logic signed [emas_pkg::TOTAL_W-1:0]  rsp_window_total,
   input logic signed [emas_pkg::SPEED_W-1:0]  rsp_speed_rpm,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [emas_pkg::CSR_AW-1:0]          csr_paddr,
   input logic [emas_pkg::CSR_DW-1:0]          csr_pwdata,
   input logic [emas_pkg::CSR_DW-1:0]          csr_prdata,
   input logic                                 csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tick_delta) &&
         $stable(rsp_window_total) && $stable(rsp_speed_rpm))
      else $error("Stalled result changed.");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result shown right after reset.");

   a_speed_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_total[emas_pkg::TOTAL_W-1] ?
         (rsp_speed_rpm[emas_pkg::SPEED_W-1] || rsp_speed_rpm == '0) :
         !rsp_speed_rpm[emas_pkg::SPEED_W-1]))
      else $error("Speed sign disagrees with window total.");

   a_gain_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready &&
         csr_paddr == emas_pkg::CSR_RPM_GAIN ##1
         csr_paddr == emas_pkg::CSR_RPM_GAIN && !csr_pwrite |->
         csr_prdata == emas_pkg::CSR_DW'($past(csr_pwdata[emas_pkg::GAIN_W-1:0])))
      else $error("Gain register reads back a wrong value.");

endmodule

bind encoder_moving_average_speed emas_checker u_emas_checker (.*);

// ===== bench/encoder_moving_average_speed_tb.sv =====
// Self-checking testbench for the encoder moving-average speed block.
`timescale 1ns / 1ps
module encoder_moving_average_speed_tb;

   localparam int                          LONG_HOLD    = 64;
   localparam logic                        APB_READ     = 1'b0;
   localparam logic                        APB_WRITE    = 1'b1;
   localparam logic [emas_pkg::CSR_AW-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic signed [emas_pkg::SAMPLE_W-1:0] delta;
      logic signed [emas_pkg::TOTAL_W-1:0]  total;
      logic signed [emas_pkg::SPEED_W-1:0]  speed;
   } speed_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [emas_pkg::SAMPLE_W-1:0]        req_count_sample = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [emas_pkg::SAMPLE_W-1:0] rsp_tick_delta;
   logic signed [emas_pkg::TOTAL_W-1:0]  rsp_window_total;
   logic signed [emas_pkg::SPEED_W-1:0]  rsp_speed_rpm;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [emas_pkg::CSR_AW-1:0]          csr_paddr = '0;
   logic [emas_pkg::CSR_DW-1:0]          csr_pwdata = '0;
   logic [emas_pkg::CSR_DW-1:0]          csr_prdata;
   logic                                 csr_pready;

   logic [emas_pkg::SAMPLE_W-1:0]        samples_to_send[$];
   speed_result_type                     speed_reports_due[$];
   speed_result_type                     due;
   logic [emas_pkg::SAMPLE_W-1:0]        plan_count = emas_pkg::COUNT_MIDPOINT;

   logic [emas_pkg::GAIN_W-1:0]          gain_now = emas_pkg::GAIN_RESET;
   logic [emas_pkg::SAMPLE_W-1:0]        last_count;
   logic signed [emas_pkg::SAMPLE_W-1:0] ring_deltas[emas_pkg::WINDOW];
   logic signed [emas_pkg::TOTAL_W-1:0]  window_sum;
   int                                   slot;

   int idle_pct = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_asks = 0;
   int holds_done = 0;
   int mismatch_count = 0;

   encoder_moving_average_speed u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_count_sample (req_count_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tick_delta   (rsp_tick_delta),
      .rsp_window_total (rsp_window_total),
      .rsp_speed_rpm    (rsp_speed_rpm),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic speed_result_type advance_window(
      input logic [emas_pkg::SAMPLE_W-1:0] sample);
      speed_result_type                     result;
      logic signed [emas_pkg::SAMPLE_W-1:0] delta;
      logic signed [emas_pkg::TOTAL_W-1:0]  total;
      longint                               sum_wide;
      longint                               gain_wide;
      longint                               scaled;
      longint                               speed_wide;
      delta = sample - last_count;
      last_count = sample;
      total = window_sum - ring_deltas[slot] + delta;
      ring_deltas[slot] = delta;
      window_sum = total;
      slot = (slot == emas_pkg::WINDOW - 1) ? 0 : slot + 1;
      sum_wide = total;
      gain_wide = gain_now;
      scaled = ((sum_wide < 0) ? -sum_wide : sum_wide) * gain_wide;
      scaled = scaled >>> emas_pkg::FRAC_W;
      if (sum_wide < 0) begin
         speed_wide = (scaled > longint'(emas_pkg::RPM_MIN_MAG)) ?
                      -longint'(emas_pkg::RPM_MIN_MAG) : -scaled;
      end else begin
         speed_wide = (scaled > longint'(emas_pkg::RPM_MAX)) ?
                      longint'(emas_pkg::RPM_MAX) : scaled;
      end
      result.delta = delta;
      result.total = total;
      result.speed = emas_pkg::SPEED_W'(speed_wide);
      return result;
   endfunction

   // Sender: each transfer is predicted at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_count_sample <= '0;
         last_count = emas_pkg::COUNT_MIDPOINT;
         window_sum = '0;
         slot = 0;
         foreach (ring_deltas[i]) ring_deltas[i] = '0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            speed_reports_due.push_back(advance_window(req_count_sample));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (samples_to_send.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
               send_gap = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_count_sample <= samples_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result transfer and drives the stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (speed_reports_due.size() == 0) begin
               $error("result transfer with nothing outstanding: tick_delta %0d",
                      rsp_tick_delta);
               mismatch_count++;
            end else begin
               due = speed_reports_due.pop_front();
               if (rsp_tick_delta !== due.delta) begin
                  $error("tick_delta: expected %0d, actual %0d", due.delta, rsp_tick_delta);
                  mismatch_count++;
               end
               if (rsp_window_total !== due.total) begin
                  $error("window_total: expected %0d, actual %0d", due.total,
                         rsp_window_total);
                  mismatch_count++;
               end
               if (rsp_speed_rpm !== due.speed) begin
                  $error("speed_rpm: expected %0d, actual %0d", due.speed, rsp_speed_rpm);
                  mismatch_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (holds_done != hold_asks) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_sample(input logic [emas_pkg::SAMPLE_W-1:0] sample);
      plan_count = sample;
      samples_to_send.push_back(sample);
   endtask

   task automatic queue_step(input int delta);
      queue_sample(plan_count + emas_pkg::SAMPLE_W'(delta));
   endtask

   // Runs of steady motion at slow, medium and full-scale speeds, mixed with noise.
   task automatic queue_runs(input int count);
      int made;
      int run;
      int vel;
      int kind;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(0, 9);
         run = $urandom_range(1, 20);
         if (kind <= 3) begin
            vel = int'($urandom_range(0, 400)) - 200;
         end else if (kind <= 5) begin
            vel = int'($urandom_range(0, 16000)) - 8000;
         end else begin
            vel = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
         end
         repeat (run) begin
            if (kind == 9) begin
               queue_sample(emas_pkg::SAMPLE_W'($urandom_range(0, 65535)));
            end else if (kind <= 5) begin
               queue_step(vel + int'($urandom_range(0, 6)) - 3);
            end else begin
               queue_step(vel);
            end
            made++;
         end
      end
   endtask

   task automatic wait_idle(input int settle);
      while (samples_to_send.size() != 0 || req_valid || speed_reports_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_access(input logic write_en,
                             input logic [emas_pkg::CSR_AW-1:0] addr,
                             input logic [emas_pkg::CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write_en;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (write_en == APB_WRITE && addr == emas_pkg::CSR_RPM_GAIN) begin
         gain_now = data[emas_pkg::GAIN_W-1:0];
      end
      if (write_en == APB_READ && csr_prdata !== emas_pkg::CSR_DW'(gain_now)) begin
         $error("rpm_gain: expected %0d, actual %0d", gain_now, csr_prdata);
         mismatch_count++;
      end
   endtask

   initial begin
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Counter extremes and wraps in both directions, then a full window
      // at the largest positive and the largest negative delta.
      idle_pct = 20;
      queue_sample(emas_pkg::COUNT_MIDPOINT);
      queue_sample(16'hFFFF);
      queue_sample(16'h0000);
      queue_sample(16'hFFFF);
      queue_sample(16'h7FFF);
      repeat (emas_pkg::WINDOW) queue_step(32767);
      repeat (emas_pkg::WINDOW) queue_step(-32768);
      wait_idle(4);
      csr_access(APB_READ, emas_pkg::CSR_RPM_GAIN, '0);

      idle_pct = 30;
      queue_runs(160);
      hold_asks++;
      wait_idle(4);

      // Full-scale gain with junk in the upper data bits; larger speeds saturate.
      csr_access(APB_WRITE, emas_pkg::CSR_RPM_GAIN, 32'hFFFF_FFFF);
      csr_access(APB_READ, emas_pkg::CSR_RPM_GAIN, '0);
      queue_runs(160);
      wait_idle(4);

      csr_access(APB_WRITE, CSR_UNMAPPED, 32'h0000_5A5A);
      csr_access(APB_READ, emas_pkg::CSR_RPM_GAIN, '0);
      csr_access(APB_WRITE, emas_pkg::CSR_RPM_GAIN, 32'h0000_0000);
      idle_pct = 10;
      queue_runs(140);
      wait_idle(4);

      csr_access(APB_WRITE, emas_pkg::CSR_RPM_GAIN, 32'd1);
      idle_pct = 40;
      queue_runs(140);
      wait_idle(4);

      csr_access(APB_WRITE, emas_pkg::CSR_RPM_GAIN, 32'h0001_0000);
      idle_pct = 0;
      queue_runs(140);
      wait_idle(4);

      for (k = 0; k < 3; k++) begin
         csr_access(APB_WRITE, emas_pkg::CSR_RPM_GAIN, $urandom());
         csr_access(APB_READ, emas_pkg::CSR_RPM_GAIN, '0);
         idle_pct = 25;
         queue_runs(140);
         if (k == 1) hold_asks++;
         wait_idle(4);
      end

      csr_access(APB_WRITE, emas_pkg::CSR_RPM_GAIN,
                 emas_pkg::CSR_DW'(emas_pkg::GAIN_RESET));
      idle_pct = 0;
      queue_runs(150);
      wait_idle(8);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
